[rtl/core/cca_pkg.sv]
// Shared types and constants for the CIGAR coverage accumulator.
package cca_pkg;

  localparam int unsigned NUM_CONTIGS      = 4;
  localparam int unsigned CONTIG_W         = 2;
  localparam int unsigned POS_W            = 16;
  localparam int unsigned CURSOR_W         = 17;
  localparam int unsigned DEPTH_W          = 16;
  localparam int unsigned LEN_W            = 16;
  localparam int unsigned ADDR_W           = CONTIG_W + POS_W;
  localparam int unsigned STORE_DEPTH      = NUM_CONTIGS << POS_W;

  localparam logic [CURSOR_W-1:0] MAP_SPAN = CURSOR_W'(1 << POS_W);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic MODE_APPLY = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [1:0] OP_MATCH = 2'd0;
  localparam logic [1:0] OP_SKIP  = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PLAN,
    ST_RUN,
    ST_FINISH
  } cca_state_t;

endpackage

[rtl/core/cigar_coverage_accumulator.sv]
// Coverage depth store updated one CIGAR operation per request.
// Read request: the registered read port fetches the depth, which ST_READ then
// registers as the result. Match/deletion request covering n positions: the
// shared read-modify-write path of the coverage memory updates one position per
// cycle. Skip, ignored, stopped requests: PLAN, FINISH. One request at a time.
// After reset the block clears its 262144-entry memory, one entry per cycle,
// with busy high; the receiver cannot stall, so each result shows for one cycle.
module cigar_coverage_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic                          in_first_op,
  input  logic [cca_pkg::CONTIG_W-1:0]  in_contig,
  input  logic [cca_pkg::POS_W-1:0]     in_start_pos,
  input  logic [cca_pkg::CURSOR_W-1:0]  in_contig_length,
  input  logic                          in_increment,
  input  logic [1:0]                    in_op_kind,
  input  logic [cca_pkg::LEN_W-1:0]     in_op_length,
  input  logic [cca_pkg::POS_W-1:0]     in_read_pos,
  output logic                          out_valid,
  output logic [cca_pkg::CURSOR_W-1:0]  out_cursor_pos,
  output logic [cca_pkg::DEPTH_W-1:0]   out_depth,
  output logic                          out_reached_end
);
  import cca_pkg::*;

  // Sequencer and alignment state.
  cca_state_t            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CURSOR_W-1:0]   cursor_r, cursor_nxt;
  logic [CONTIG_W-1:0]   contig_r, contig_nxt;
  logic [CURSOR_W-1:0]   length_r, length_nxt;
  logic                  adding_r, adding_nxt;
  logic                  stopped_r, stopped_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [LEN_W-1:0]      oplen_r, oplen_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;

  // Write-back stage of the read-modify-write pipeline.
  logic                  wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]     wr_addr_r, wr_addr_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [CURSOR_W-1:0]   out_cursor_r, out_cursor_nxt;
  logic [DEPTH_W-1:0]    out_depth_r, out_depth_nxt;
  logic                  out_end_r, out_end_nxt;

  // Memory port signals.
  logic [DEPTH_W-1:0]    mem [STORE_DEPTH];
  logic [DEPTH_W-1:0]    mem_q;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DEPTH_W-1:0]    wr_data;

  logic                  accept;
  logic [CURSOR_W-1:0]   lim;
  logic [CURSOR_W-1:0]   room;
  logic [CURSOR_W-1:0]   len_ext;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign len_ext = {1'b0, oplen_r};
  // The contig end is the requested length, capped at the 65536 positions of
  // one map, since a 17-bit length can reach beyond the map.
  assign lim     = (length_r > MAP_SPAN) ? MAP_SPAN : length_r;
  assign room    = lim - cursor_r;

  // The write port is shared by the clearing sweep and the update pipeline;
  // the two never overlap because updates only run after the sweep ends.
  assign wr_en   = (state_r == ST_CLEAR) || wr_pend_r;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr_r;

  // Zero during the clearing sweep, else a saturating increment, or decrement
  // that stops at zero, of the depth that the registered read port returned.
  always_comb begin
    wr_data = mem_q;
    if (state_r == ST_CLEAR) begin
      wr_data = '0;
    end else if (adding_r) begin
      if (mem_q != DEPTH_MAX) begin
        wr_data = mem_q + DEPTH_W'(1);
      end
    end else if (mem_q != '0) begin
      wr_data = mem_q - DEPTH_W'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cursor_nxt     = cursor_r;
    contig_nxt     = contig_r;
    length_nxt     = length_r;
    adding_nxt     = adding_r;
    stopped_nxt    = stopped_r;
    kind_nxt       = kind_r;
    oplen_nxt      = oplen_r;
    cnt_nxt        = cnt_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    out_valid_nxt  = 1'b0;
    out_cursor_nxt = out_cursor_r;
    out_depth_nxt  = out_depth_r;
    out_end_nxt    = out_end_r;
    rd_en          = 1'b0;
    rd_addr        = {contig_r, cursor_r[POS_W-1:0]};

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          kind_nxt  = in_op_kind;
          oplen_nxt = in_op_length;
          if (in_mode == MODE_READ) begin
            // The read port fetches the stored depth right away.
            rd_en     = 1'b1;
            rd_addr   = {in_contig, in_read_pos};
            state_nxt = ST_READ;
          end else begin
            if (in_first_op) begin
              contig_nxt  = in_contig;
              cursor_nxt  = {1'b0, in_start_pos};
              length_nxt  = in_contig_length;
              adding_nxt  = in_increment;
              stopped_nxt = 1'b0;
            end
            state_nxt = ST_PLAN;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_cursor_nxt = cursor_r;
        out_depth_nxt  = mem_q;
        out_end_nxt    = stopped_r;
        state_nxt      = ST_IDLE;
      end

      ST_PLAN: begin
        state_nxt = ST_FINISH;
        if (!stopped_r) begin
          if (kind_r == OP_MATCH) begin
            // Cut the run at the contig end.
            if ((cursor_r < lim) && (oplen_r != '0)) begin
              cnt_nxt   = (len_ext < room) ? oplen_r : room[LEN_W-1:0];
              state_nxt = ST_RUN;
            end
          end else if (kind_r == OP_SKIP) begin
            cursor_nxt = cursor_r + len_ext;
          end
        end
      end

      ST_RUN: begin
        // Issue the read of one position; its write-back follows next cycle.
        rd_en       = 1'b1;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = rd_addr;
        cursor_nxt  = cursor_r + CURSOR_W'(1);
        cnt_nxt     = cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // A cursor at or beyond the contig end stops the alignment.
        stopped_nxt    = stopped_r || (cursor_r >= lim);
        out_valid_nxt  = 1'b1;
        out_cursor_nxt = cursor_r;
        out_depth_nxt  = '0;
        out_end_nxt    = stopped_r || (cursor_r >= lim);
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      contig_r    <= '0;
      length_r    <= '0;
      adding_r    <= 1'b0;
      stopped_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cursor_r    <= cursor_nxt;
      contig_r    <= contig_nxt;
      length_r    <= length_nxt;
      adding_r    <= adding_nxt;
      stopped_r   <= stopped_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    oplen_r      <= oplen_nxt;
    cnt_r        <= cnt_nxt;
    wr_addr_r    <= wr_addr_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_depth_r  <= out_depth_nxt;
    out_end_r    <= out_end_nxt;
  end

  // Coverage memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_pos  = out_cursor_r;
  assign out_depth       = out_depth_r;
  assign out_reached_end = out_end_r;

  // A result is a single-cycle strobe, since every request leaves IDLE before its result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // All write-backs of a run have landed before a new request can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_pend_r)
    else $error("write-back still pending while idle");

  // Updates only ever touch positions inside the contig.
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cursor_r < lim) && (cnt_r != '0))
    else $error("update issued beyond the contig end");

  // The reported cursor and stop flag match the alignment state.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cursor_r == cursor_r) && (out_end_r == stopped_r))
    else $error("result disagrees with alignment state");

endmodule

[bench/cigar_coverage_accumulator_tb.sv]
// Self-checking testbench for the CIGAR coverage accumulator with its own depth predictor.
`timescale 1ns / 1ps

module cigar_coverage_accumulator_tb;
  import cca_pkg::*;

  // Op kinds beyond match and skip have no names in the package. Both are ignored.
  localparam logic [1:0] OP_IGNORED  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int unsigned CONTIG_SPAN = 1 << POS_W;

  // A correct block can stay quiet through the clear of its 262144-entry store after reset,
  // and through a full 65535-position run. The limit is several times the longer one.
  localparam int unsigned QUIET_LIMIT = 800000;

  localparam int unsigned RANDOM_REQUESTS = 780;

  typedef struct {
    logic                mode;
    logic                first_op;
    logic [CONTIG_W-1:0] contig;
    logic [POS_W-1:0]    start_pos;
    logic [CURSOR_W-1:0] contig_length;
    logic                increment;
    logic [1:0]          op_kind;
    logic [LEN_W-1:0]    op_length;
    logic [POS_W-1:0]    read_pos;
  } cigar_req_t;

  typedef struct {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [DEPTH_W-1:0]  depth;
    logic                reached_end;
  } coverage_result_t;

  // The scoreboard keeps its own copy of the depth store and the alignment state.
  // Each accepted request is applied to that copy, and the result it should produce
  // is queued. Each strobed result is compared with the oldest queued one.
  class coverage_scoreboard;
    bit [DEPTH_W-1:0]  depth_map [STORE_DEPTH];
    bit [CURSOR_W-1:0] cursor;
    bit [CONTIG_W-1:0] cur_contig;
    bit [CURSOR_W-1:0] cur_length;
    bit                adding;
    bit                stopped;
    coverage_result_t  pending [$];
    int                mismatches;

    function bit [CURSOR_W-1:0] end_of_contig(input bit [CURSOR_W-1:0] length);
      return (length > CONTIG_SPAN) ? CURSOR_W'(CONTIG_SPAN) : length;
    endfunction

    function void bump(input int unsigned addr);
      if (adding) begin
        if (depth_map[addr] != DEPTH_MAX) depth_map[addr] = depth_map[addr] + 1'b1;
      end else if (depth_map[addr] != '0) begin
        depth_map[addr] = depth_map[addr] - 1'b1;
      end
    endfunction

    // Positions a match request would cover before the contig end.
    function int unsigned room_for(input cigar_req_t r);
      bit [CURSOR_W-1:0] cur;
      bit [CURSOR_W-1:0] lim;
      bit                halted;
      cur    = r.first_op ? CURSOR_W'(r.start_pos) : cursor;
      lim    = end_of_contig(r.first_op ? r.contig_length : cur_length);
      halted = r.first_op ? 1'b0 : stopped;
      if (halted || cur >= lim) return 0;
      return lim - cur;
    endfunction

    function void note(input cigar_req_t r);
      coverage_result_t  e;
      bit [CURSOR_W-1:0] lim;
      bit [CURSOR_W-1:0] n;
      int unsigned       base;
      int unsigned       k;
      e.depth = '0;
      if (r.mode == MODE_READ) begin
        e.depth = depth_map[{r.contig, r.read_pos}];
      end else begin
        if (r.first_op) begin
          cur_contig = r.contig;
          cursor     = CURSOR_W'(r.start_pos);
          cur_length = r.contig_length;
          adding     = r.increment;
          stopped    = 1'b0;
        end
        if (!stopped) begin
          lim = end_of_contig(cur_length);
          if (r.op_kind == OP_MATCH) begin
            if (cursor < lim) begin
              n = lim - cursor;
              if (r.op_length < n) n = CURSOR_W'(r.op_length);
              base = cur_contig * CONTIG_SPAN + cursor;
              for (k = 0; k < n; k++) bump(base + k);
              cursor = cursor + n;
            end
          end else if (r.op_kind == OP_SKIP) begin
            // A skip may carry the cursor past the end; it wraps at 17 bits.
            cursor = cursor + CURSOR_W'(r.op_length);
          end
          if (cursor >= lim) stopped = 1'b1;
        end
      end
      e.cursor_pos  = cursor;
      e.reached_end = stopped;
      pending.insert(pending.size(), e);
    endfunction

    function void check(input logic [CURSOR_W-1:0] cursor_pos, input logic [DEPTH_W-1:0] depth,
                        input logic reached_end);
      coverage_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: cursor_pos=%0d depth=%0d reached_end=%0b",
               cursor_pos, depth, reached_end);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (cursor_pos !== e.cursor_pos) begin
        $error("cursor_pos: expected %0d, actual %0d", e.cursor_pos, cursor_pos);
        mismatches++;
      end
      if (depth !== e.depth) begin
        $error("depth: expected %0d, actual %0d", e.depth, depth);
        mismatches++;
      end
      if (reached_end !== e.reached_end) begin
        $error("reached_end: expected %0b, actual %0b", e.reached_end, reached_end);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic                in_first_op;
  logic [CONTIG_W-1:0] in_contig;
  logic [POS_W-1:0]    in_start_pos;
  logic [CURSOR_W-1:0] in_contig_length;
  logic                in_increment;
  logic [1:0]          in_op_kind;
  logic [LEN_W-1:0]    in_op_length;
  logic [POS_W-1:0]    in_read_pos;
  logic                out_valid;
  logic [CURSOR_W-1:0] out_cursor_pos;
  logic [DEPTH_W-1:0]  out_depth;
  logic                out_reached_end;

  coverage_scoreboard sb;
  int unsigned        quiet_cycles = 0;

  cigar_coverage_accumulator DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_cursor_pos, out_depth, out_reached_end);
  end

  // The watchdog counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("cigar_coverage_accumulator_tb NOT OK");
      $finish;
    end
  end

  // The first operation of an alignment. Read position is a don't-care here.
  function automatic cigar_req_t make_first(input logic [CONTIG_W-1:0] contig,
                                            input logic [POS_W-1:0] start_pos,
                                            input logic [CURSOR_W-1:0] contig_length,
                                            input logic increment, input logic [1:0] kind,
                                            input logic [LEN_W-1:0] length);
    cigar_req_t r;
    r.mode          = MODE_APPLY;
    r.first_op      = 1'b1;
    r.contig        = contig;
    r.start_pos     = start_pos;
    r.contig_length = contig_length;
    r.increment     = increment;
    r.op_kind       = kind;
    r.op_length     = length;
    r.read_pos      = POS_W'($urandom);
    return r;
  endfunction

  // A follow-on operation. The fields that only the first operation loads are
  // randomized so that a block which wrongly takes them shows up.
  function automatic cigar_req_t make_cont(input logic [1:0] kind, input logic [LEN_W-1:0] length);
    cigar_req_t r;
    r = make_first(CONTIG_W'($urandom), POS_W'($urandom), CURSOR_W'($urandom),
                   1'($urandom), kind, length);
    r.first_op = 1'b0;
    return r;
  endfunction

  // A depth read. Every other field, first_op included, must be ignored.
  function automatic cigar_req_t make_read(input logic [CONTIG_W-1:0] contig,
                                           input logic [POS_W-1:0] pos);
    cigar_req_t r;
    r = make_first(contig, POS_W'($urandom), CURSOR_W'($urandom), 1'($urandom),
                   2'($urandom), LEN_W'($urandom));
    r.mode     = MODE_READ;
    r.first_op = 1'($urandom);
    r.read_pos = pos;
    return r;
  endfunction

  function automatic logic [1:0] random_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return OP_MATCH;
    if (roll < 80) return OP_SKIP;
    if (roll < 90) return OP_IGNORED;
    return OP_RESERVED;
  endfunction

  // Match runs cost one cycle per covered position, so long runs are only drawn
  // when the contig end is close and will cut them short. Other kinds are cheap.
  function automatic logic [LEN_W-1:0] pick_length(input cigar_req_t r);
    if (r.op_kind == OP_MATCH) begin
      if (sb.room_for(r) <= 2048 && $urandom_range(0, 3) == 0) return LEN_W'($urandom);
      return LEN_W'($urandom_range(0, 160));
    end
    if (r.op_kind == OP_SKIP && $urandom_range(0, 99) >= 15) return LEN_W'($urandom_range(0, 200));
    return LEN_W'($urandom);
  endfunction

  // Called at a falling edge. Presents one request and returns at the falling
  // edge after it was accepted, with start still high so that the next request
  // can follow back to back. Busy only moves on a rising edge, so its value at
  // this falling edge decides whether the coming rising edge accepts the request.
  task automatic send(input cigar_req_t r, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 11) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode          <= r.mode;
    in_first_op      <= r.first_op;
    in_contig        <= r.contig;
    in_start_pos     <= r.start_pos;
    in_contig_length <= r.contig_length;
    in_increment     <= r.increment;
    in_op_kind       <= r.op_kind;
    in_op_length     <= r.op_length;
    in_read_pos      <= r.read_pos;
    start            <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    sb.note(r);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Mostly well-formed alignments around a few hot spots, so that reads find
  // nonzero depths, mixed with reads and with loose operations in any state.
  task automatic random_traffic(input int total);
    cigar_req_t          r;
    int                  sent;
    int                  ops;
    int                  roll;
    int                  j;
    bit                  calm;
    logic [CONTIG_W-1:0] hot_contig;
    logic [POS_W-1:0]    hot_pos;
    logic [POS_W-1:0]    base;
    logic [CURSOR_W-1:0] clen;
    sent       = 0;
    hot_contig = '0;
    hot_pos    = '0;
    while (sent < total) begin
      // One stretch of requests goes out with no idle cycles at all.
      calm = (sent >= 300 && sent < 450);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        if ($urandom_range(0, 3) != 0) begin
          r = make_read(hot_contig, hot_pos + POS_W'($urandom_range(0, 200)));
        end else begin
          r = make_read(CONTIG_W'($urandom), POS_W'($urandom));
        end
        send(r, !calm);
        sent++;
      end else if (roll < 25) begin
        // A loose operation: first_op may or may not be set, any fields.
        r = make_first(CONTIG_W'($urandom), POS_W'($urandom), CURSOR_W'($urandom),
                       1'($urandom), 2'($urandom), '0);
        r.first_op  = 1'($urandom);
        r.op_length = pick_length(r);
        send(r, !calm);
        sent++;
      end else begin
        ops = $urandom_range(1, 6);
        case ($urandom_range(0, 3))
          0: begin
            base = 16'd0;
          end
          1: begin
            base = 16'd1200;
          end
          2: begin
            base = 16'd32768;
          end
          default: begin
            base = 16'd65400;
          end
        endcase
        hot_contig = CONTIG_W'($urandom);
        if ($urandom_range(0, 9) == 0) hot_pos = POS_W'($urandom);
        else hot_pos = base + POS_W'($urandom_range(0, 300));
        roll = $urandom_range(0, 9);
        if (roll < 6) clen = CURSOR_W'(CONTIG_SPAN);
        else if (roll < 8) clen = CURSOR_W'($urandom);
        else clen = CURSOR_W'(hot_pos) + CURSOR_W'($urandom_range(0, 400));
        for (j = 0; j < ops; j++) begin
          if (j == 0) begin
            r = make_first(hot_contig, hot_pos, clen, $urandom_range(0, 99) < 65,
                           random_kind(), '0);
          end else begin
            r = make_cont(random_kind(), '0);
          end
          r.op_length = pick_length(r);
          send(r, !calm);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int i;
    sb               = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_mode         <= MODE_APPLY;
    in_first_op     <= 1'b0;
    in_contig       <= '0;
    in_start_pos    <= '0;
    in_contig_length <= '0;
    in_increment    <= 1'b0;
    in_op_kind      <= OP_MATCH;
    in_op_length    <= '0;
    in_read_pos     <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests. The block clears its store first with busy high, so the
    // first request simply waits for that to finish.
    send(make_read(2'd0, 16'd0), 1'b1);
    // Operations with no first operation run against the reset state: the
    // contig length is zero, so nothing is written and the alignment stops.
    send(make_cont(OP_MATCH, 16'd5), 1'b1);
    // A stopped alignment ignores further operations and holds its cursor.
    send(make_cont(OP_SKIP, 16'd9), 1'b1);
    // A maximal match run near the top of the last contig is cut at its end.
    send(make_first(2'd3, 16'hFFFA, 17'h10000, 1'b1, OP_MATCH, 16'hFFFF), 1'b1);
    send(make_read(2'd3, 16'hFFFF), 1'b1);
    // A contig length beyond the map is capped at the map size.
    send(make_first(2'd3, 16'hFFFE, 17'h1FFFF, 1'b0, OP_MATCH, 16'hFFFF), 1'b1);
    // Removing coverage from a position that is already zero leaves it at zero.
    send(make_first(2'd3, 16'hFFFF, 17'h1FFFF, 1'b0, OP_MATCH, 16'd1), 1'b1);
    send(make_read(2'd3, 16'hFFFF), 1'b1);
    send(make_read(2'd3, 16'hFFFA), 1'b1);
    // A start beyond the contig end runs the first operation, writes nothing, stops.
    send(make_first(2'd1, 16'd100, 17'd50, 1'b1, OP_MATCH, 16'd10), 1'b1);
    // A skip may carry the cursor well past the end; later operations are ignored.
    send(make_first(2'd2, 16'd10, 17'd20, 1'b1, OP_SKIP, 16'hFFFF), 1'b1);
    send(make_cont(OP_MATCH, 16'd4), 1'b1);
    // Ignored op kinds, a zero-length match, then a mix of match and skip.
    send(make_first(2'd2, 16'd5, 17'd1000, 1'b1, OP_IGNORED, 16'd77), 1'b1);
    send(make_cont(OP_RESERVED, 16'd9), 1'b1);
    send(make_cont(OP_MATCH, 16'd0), 1'b1);
    send(make_cont(OP_MATCH, 16'd3), 1'b1);
    send(make_cont(OP_SKIP, 16'd4), 1'b1);
    send(make_cont(OP_MATCH, 16'd2), 1'b1);
    send(make_read(2'd2, 16'd6), 1'b1);
    // A contig length of zero stops the alignment at once.
    send(make_first(2'd0, 16'd7, 17'd0, 1'b1, OP_MATCH, 16'd3), 1'b1);
    // One run over the whole first contig, then the last position ends it.
    send(make_first(2'd0, 16'd0, 17'h10000, 1'b1, OP_MATCH, 16'hFFFF), 1'b1);
    send(make_cont(OP_MATCH, 16'd1), 1'b1);
    send(make_read(2'd0, 16'd0), 1'b1);
    send(make_read(2'd0, 16'hFFFF), 1'b1);

    // Let the block fall fully idle before the next phase.
    drain();

    // One position is covered many times over, then one removal steps it
    // down by one. These requests go out back to back with no idle cycles.
    for (i = 0; i < 40; i++) begin
      send(make_first(2'd1, 16'd7, CURSOR_W'($urandom_range(8, 131071)), 1'b1,
                      OP_MATCH, 16'd1), 1'b0);
    end
    send(make_read(2'd1, 16'd7), 1'b0);
    send(make_first(2'd1, 16'd7, 17'h10000, 1'b0, OP_MATCH, 16'd1), 1'b0);
    send(make_read(2'd1, 16'd7), 1'b0);

    random_traffic(RANDOM_REQUESTS);

    // Wait for the last results, then keep watching for any stray strobe.
    drain();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("cigar_coverage_accumulator_tb OK");
    end else begin
      $display("cigar_coverage_accumulator_tb NOT OK");
    end
    $finish;
  end

endmodule
